// ===== src/hse_pkg.sv =====
// Shared types and constants for the heap sort engine.
`timescale 1ns / 1ps
package hse_pkg;

   localparam int unsigned HSE_CAPACITY = 32;
   localparam int unsigned KEY_W        = 32;

   typedef logic signed [KEY_W-1:0] key_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_NODE,
      ST_LOAD_MOVE,
      ST_CHECK,
      ST_CHILD,
      ST_SIBLING,
      ST_DECIDE,
      ST_SIFT_DONE,
      ST_SW_RD_ROOT,
      ST_SW_RD_LAST,
      ST_SW_WR_ROOT,
      ST_SW_WR_LAST,
      ST_EMIT
   } state_type;

   typedef enum logic {
      CMP_SIBLING,
      CMP_DECIDE
   } cmp_sel_type;

   typedef struct packed {
      logic wr_en;
      logic go;
      logic ovf;
   } load_ctl_type;

endpackage

// ===== src/hse_cmp.sv =====
// Shared signed key comparator with operand select.
`timescale 1ns / 1ps
module hse_cmp (
   input  hse_pkg::cmp_sel_type sel,
   input  hse_pkg::key_type     moving,
   input  hse_pkg::key_type     best,
   input  hse_pkg::key_type     rd_data,
   output logic                 less
);
   import hse_pkg::*;

   key_type op_a;
   key_type op_b;

   always_comb begin
      unique case (sel)
         CMP_SIBLING: begin
            op_a = best;
            op_b = rd_data;
         end
         CMP_DECIDE: begin
            op_a = moving;
            op_b = best;
         end
         default: begin
            op_a = moving;
            op_b = best;
         end
      endcase
   end

   assign less = (op_a < op_b);

endmodule

// ===== src/hse_core.sv =====
// Key store, heapsort sequencer and result emission.
`timescale 1ns / 1ps
module hse_core #(
   parameter int unsigned CAPACITY = hse_pkg::HSE_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  hse_pkg::load_ctl_type              load_ctl,
   input  logic [$clog2(CAPACITY)-1:0]        load_addr,
   input  hse_pkg::key_type                   load_data,
   input  logic [$clog2(CAPACITY+1)-1:0]      batch_n,
   output logic                               busy,
   output logic                               rsp_strobe,
   output hse_pkg::key_type                   rsp_key,
   output logic                               rsp_final,
   output logic                               rsp_ovf
);
   import hse_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic [KEY_W-1:0] key_store_ff [CAPACITY];

   state_type   state_ff, state_in;
   logic [AW-1:0] node_ff, node_in;
   logic [AW-1:0] last_ff, last_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] top_ff, top_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic          build_ff, build_in;
   logic          ovf_ff, ovf_in;
   logic          strobe_ff, strobe_in;
   logic          final_ff, final_in;
   logic          rsp_ovf_ff;
   key_type       moving_ff, moving_in;
   key_type       best_ff, best_in;
   key_type       tmp_ff, tmp_in;
   key_type       rd_data_ff;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   key_type       wr_data;
   cmp_sel_type   cmp_sel;
   logic          less;

   logic [AW:0]   child;
   logic [AW-1:0] child_lo;
   logic          child_past_last;
   logic          child_below_last;

   assign child            = {node_ff, 1'b1};
   assign child_lo         = child[AW-1:0];
   assign child_past_last  = child > {1'b0, last_ff};
   assign child_below_last = child < {1'b0, last_ff};

   hse_cmp u_cmp (
      .sel     (cmp_sel),
      .moving  (moving_ff),
      .best    (best_ff),
      .rd_data (rd_data_ff),
      .less    (less)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load_ctl.go) begin
               state_in = (batch_n == CW'(1)) ? ST_EMIT : ST_RD_NODE;
            end
         end
         ST_RD_NODE:    state_in = ST_LOAD_MOVE;
         ST_LOAD_MOVE:  state_in = ST_CHECK;
         ST_CHECK:      state_in = child_past_last ? ST_SIFT_DONE : ST_CHILD;
         ST_CHILD:      state_in = child_below_last ? ST_SIBLING : ST_DECIDE;
         ST_SIBLING:    state_in = ST_DECIDE;
         ST_DECIDE:     state_in = less ? ST_CHECK : ST_SIFT_DONE;
         ST_SIFT_DONE: begin
            if (build_ff) begin
               state_in = (i_ff > AW'(1)) ? ST_RD_NODE : ST_SW_RD_ROOT;
            end else begin
               state_in = (i_ff > AW'(1)) ? ST_SW_RD_ROOT : ST_EMIT;
            end
         end
         ST_SW_RD_ROOT: state_in = ST_SW_RD_LAST;
         ST_SW_RD_LAST: state_in = ST_SW_WR_ROOT;
         ST_SW_WR_ROOT: state_in = ST_SW_WR_LAST;
         ST_SW_WR_LAST: state_in = ST_CHECK;
         ST_EMIT:       state_in = (k_ff == top_ff) ? ST_IDLE : ST_EMIT;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      node_in     = node_ff;
      last_in     = last_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      top_in      = top_ff;
      best_idx_in = best_idx_ff;
      build_in    = build_ff;
      ovf_in      = ovf_ff;
      moving_in   = moving_ff;
      best_in     = best_ff;
      tmp_in      = tmp_ff;
      strobe_in   = 1'b0;
      final_in    = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = node_ff;
      wr_en       = 1'b0;
      wr_addr     = node_ff;
      wr_data     = moving_ff;
      cmp_sel     = CMP_DECIDE;
      unique case (state_ff)
         ST_IDLE: begin
            wr_en   = load_ctl.wr_en;
            wr_addr = load_addr;
            wr_data = load_data;
            if (load_ctl.go) begin
               top_in   = AW'(batch_n - CW'(1));
               last_in  = AW'(batch_n - CW'(1));
               i_in     = AW'(batch_n >> 1);
               node_in  = AW'((batch_n >> 1) - CW'(1));
               build_in = 1'b1;
               k_in     = '0;
               ovf_in   = load_ctl.ovf;
            end
         end
         ST_RD_NODE: begin
            rd_en   = 1'b1;
            rd_addr = node_ff;
         end
         ST_LOAD_MOVE: begin
            moving_in = rd_data_ff;
         end
         ST_CHECK: begin
            if (child_past_last) begin
               wr_en = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = child_lo;
            end
         end
         ST_CHILD: begin
            best_in     = rd_data_ff;
            best_idx_in = child_lo;
            if (child_below_last) begin
               rd_en   = 1'b1;
               rd_addr = child_lo + AW'(1);
            end
         end
         ST_SIBLING: begin
            cmp_sel = CMP_SIBLING;
            if (less) begin
               best_in     = rd_data_ff;
               best_idx_in = best_idx_ff + AW'(1);
            end
         end
         ST_DECIDE: begin
            wr_en = 1'b1;
            if (less) begin
               wr_data = best_ff;
               node_in = best_idx_ff;
            end
         end
         ST_SIFT_DONE: begin
            if (build_ff) begin
               if (i_ff > AW'(1)) begin
                  i_in    = i_ff - AW'(1);
                  node_in = i_ff - AW'(2);
               end else begin
                  build_in = 1'b0;
                  i_in     = top_ff;
               end
            end else if (i_ff > AW'(1)) begin
               i_in = i_ff - AW'(1);
            end
         end
         ST_SW_RD_ROOT: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         ST_SW_RD_LAST: begin
            tmp_in  = rd_data_ff;
            rd_en   = 1'b1;
            rd_addr = i_ff;
         end
         ST_SW_WR_ROOT: begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = rd_data_ff;
            moving_in = rd_data_ff;
         end
         ST_SW_WR_LAST: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = tmp_ff;
            node_in = '0;
            last_in = i_ff - AW'(1);
         end
         ST_EMIT: begin
            rd_en     = 1'b1;
            rd_addr   = k_ff;
            strobe_in = 1'b1;
            final_in  = (k_ff == top_ff);
            k_in      = k_ff + AW'(1);
         end
         default: begin
         end
      endcase
   end

   // key store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_type'(key_store_ff[rd_addr]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      last_ff     <= last_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      top_ff      <= top_in;
      best_idx_ff <= best_idx_in;
      build_ff    <= build_in;
      ovf_ff      <= ovf_in;
      moving_ff   <= moving_in;
      best_ff     <= best_in;
      tmp_ff      <= tmp_in;
      final_ff    <= final_in;
      rsp_ovf_ff  <= ovf_ff;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_key    = rd_data_ff;
   assign rsp_final  = final_ff;
   assign rsp_ovf    = rsp_ovf_ff;

endmodule

// ===== src/heap_sort_engine.sv =====
// Top level of the batch heap sort engine: key loading and result ports.
`timescale 1ns / 1ps
// Keys enter one beat per cycle while busy is low (a beat is taken when start is high
// and busy is low); the beat with req_batch_end set closes the batch and starts the sort.
// Up to CAPACITY keys are kept; further keys are dropped and every result of that batch
// carries rsp_overflowed. After the closing beat, busy stays high while the key store,
// with one write and one read port, is heap-sorted in place: each sift level reads the
// child, reads its sibling, compares, and writes back; each of the N/2 build sifts and
// N-1 extraction sifts walks up to log2 N levels, and each extraction swap reads the root
// and the last key and writes both back. The pace is set by the one read port of the
// store and the one shared comparator. The N sorted keys then come out on consecutive
// cycles, ascending, each marked by rsp_strobe for exactly one cycle and rsp_final_res
// on the last. The receiver cannot stall: a result must be taken in the cycle it is
// shown. busy drops in the cycle that shows the last result, so the next batch may
// begin loading right away.
module heap_sort_engine #(
   parameter int unsigned CAPACITY = hse_pkg::HSE_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hse_pkg::key_type req_key,
   input  logic             req_batch_end,
   output logic             rsp_strobe,
   output hse_pkg::key_type rsp_sorted_key,
   output logic             rsp_final_res,
   output logic             rsp_overflowed
);
   import hse_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          accept;
   logic          room;
   logic [CW-1:0] count_next;
   logic          ovf_next;
   load_ctl_type  load_ctl;

   // take a beat only while the sorter is idle
   assign accept = start & ~busy;

   // drop the key once the store is full, but remember that one was dropped
   assign room       = (count_ff < CW'(CAPACITY));
   assign count_next = room ? (count_ff + CW'(1)) : count_ff;
   assign ovf_next   = ovf_ff | ~room;

   assign load_ctl.wr_en = accept & room;
   assign load_ctl.go    = accept & req_batch_end;
   assign load_ctl.ovf   = ovf_next;

   // hold the fill count between beats; clear it when the batch closes
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_batch_end) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = count_next;
            ovf_in   = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   hse_core #(
      .CAPACITY (CAPACITY)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .load_ctl   (load_ctl),
      .load_addr  (count_ff[AW-1:0]),
      .load_data  (req_key),
      .batch_n    (count_next),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_key    (rsp_sorted_key),
      .rsp_final  (rsp_final_res),
      .rsp_ovf    (rsp_overflowed)
   );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the batch heap sort engine.
`timescale 1ns / 1ps
module tb;
   import hse_pkg::*;

   localparam int unsigned CAP         = HSE_CAPACITY;
   localparam int unsigned ITEM_TARGET = 470;
   // The last stretch of beats goes in back to back.
   localparam int unsigned TAIL_BEATS  = 60;
   // A full 32-key sort runs with no beat or result shown;
   // allow many times its length before calling it a hang.
   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned DRAIN_WAIT  = 40;

   typedef struct {
      key_type     key;
      logic        last;
      int unsigned gap;     // idle cycles before this beat is shown
   } key_beat;

   typedef struct {
      key_type key;
      logic    final_flag;
      logic    ovf;
   } sorted_result;

   logic    clock;
   logic    reset         = 1'b1;
   logic    start         = 1'b0;
   key_type req_key       = '0;
   logic    req_batch_end = 1'b0;
   logic    busy;
   logic    rsp_strobe;
   key_type rsp_sorted_key;
   logic    rsp_final_res;
   logic    rsp_overflowed;

   key_beat      pending_keys[$];
   sorted_result sorted_expect[$];

   // Predictor's copy of the batch being collected.
   key_type     held_keys [CAP];
   int unsigned held_count   = 0;
   logic        held_dropped = 1'b0;

   int unsigned beats_total      = 0;
   int unsigned beats_accepted   = 0;
   int unsigned batches_closed   = 0;
   int unsigned overflow_batches = 0;
   int unsigned results_checked  = 0;
   int unsigned mismatch_count   = 0;
   int unsigned quiet_cycles     = 0;
   int unsigned gap_left         = 0;

   heap_sort_engine dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_key        (req_key),
      .req_batch_end  (req_batch_end),
      .rsp_strobe     (rsp_strobe),
      .rsp_sorted_key (rsp_sorted_key),
      .rsp_final_res  (rsp_final_res),
      .rsp_overflowed (rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at result %0d: %s got %h expected %h",
               results_checked, what, got, want);
      mismatch_count++;
   endtask

   // Queue one key beat; the tail of the run carries no idle gaps.
   task automatic add_key(input key_type key, input logic last, input int unsigned gap);
      key_beat b;
      b.key  = key;
      b.last = last;
      b.gap  = (beats_total >= ITEM_TARGET - TAIL_BEATS) ? 0 : gap;
      pending_keys.push_back(b);
      beats_total++;
   endtask

   // Predictor: hold keys up to capacity, flag drops, and on the closing beat
   // queue the held keys in ascending order with the final and overflow flags.
   task automatic take_key(input key_type key, input logic last);
      key_type      moving;
      int           j;
      sorted_result r;
      if (held_count < CAP) begin
         held_keys[held_count] = key;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (last) begin
         for (int i = 1; i < held_count; i++) begin
            moving = held_keys[i];
            j = i - 1;
            while (j >= 0 && held_keys[j] > moving) begin
               held_keys[j + 1] = held_keys[j];
               j--;
            end
            held_keys[j + 1] = moving;
         end
         for (int k = 0; k < held_count; k++) begin
            r.key        = held_keys[k];
            r.final_flag = (k == held_count - 1);
            r.ovf        = held_dropped;
            sorted_expect.push_back(r);
         end
         batches_closed++;
         if (held_dropped) overflow_batches++;
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endtask

   // Driver: once the shown beat is taken (or nothing is shown), count down
   // any idle gap, then present the next pending key. While busy is high,
   // hold the current beat untouched.
   always @(posedge clock) begin : driver
      key_beat nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_keys.size() != 0 && pending_keys[0].gap != 0) begin
            // Open a burst of idle cycles; this edge is its first cycle.
            gap_left = pending_keys[0].gap - 1;
            pending_keys[0].gap = 0;
            start <= 1'b0;
         end else if (pending_keys.size() != 0) begin
            nxt = pending_keys.pop_front();
            start         <= 1'b1;
            req_key       <= nxt.key;
            req_batch_end <= nxt.last;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check each strobed result against the oldest expectation, then
   // feed any beat taken at this edge to the predictor. Results for a batch
   // can never show at the edge that closes it, so the order here is safe.
   always @(posedge clock) begin : monitor
      sorted_result want;
      logic         active;
      if (!reset) begin
         active = 1'b0;
         if (rsp_strobe) begin
            active = 1'b1;
            if (sorted_expect.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_sorted_key, '0);
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_sorted_key !== want.key)
                  report_mismatch("sorted_key", rsp_sorted_key, want.key);
               if (rsp_final_res !== want.final_flag)
                  report_mismatch("final_res", rsp_final_res, want.final_flag);
               if (rsp_overflowed !== want.ovf)
                  report_mismatch("overflowed", rsp_overflowed, want.ovf);
            end
            results_checked++;
         end
         if (start && !busy) begin
            active = 1'b1;
            take_key(req_key, req_batch_end);
            beats_accepted++;
         end
         quiet_cycles = active ? 0 : quiet_cycles + 1;
      end
   end

   // Watchdog: sample away from the active edge and stop a hung run.
   initial begin : watchdog
      @(negedge clock);
      while (quiet_cycles < STALL_LIMIT) @(negedge clock);
      $display("TIMEOUT: no beat or result for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned n;
      int unsigned mode;
      int unsigned sel;
      logic        calm;
      key_type     k;

      // Directed: single-key batches at the extremes, mixed extremes with
      // duplicates and alternating bit patterns, ordered and reversed pairs,
      // and an all-equal batch.
      add_key(32'sh8000_0000, 1'b1, 0);
      add_key(32'sh7fff_ffff, 1'b1, 3);
      add_key('0, 1'b1, 0);
      add_key(32'sh7fff_ffff, 1'b0, 0);
      add_key(32'sh8000_0000, 1'b0, 1);
      add_key(-32'sd1, 1'b0, 0);
      add_key(32'sd1, 1'b0, 0);
      add_key('0, 1'b0, 2);
      add_key(32'sd7, 1'b0, 0);
      add_key(32'sd7, 1'b0, 0);
      add_key(-32'sd7, 1'b0, 0);
      add_key(32'sh5555_5555, 1'b0, 0);
      add_key(32'shaaaa_aaaa, 1'b1, 0);
      add_key(-32'sd5, 1'b0, 0);
      add_key(32'sd5, 1'b1, 0);
      add_key(32'sd5, 1'b0, 0);
      add_key(-32'sd5, 1'b1, 0);
      add_key(32'sd42, 1'b0, 0);
      add_key(32'sd42, 1'b0, 5);
      add_key(32'sd42, 1'b1, 0);

      // Random batches: about half short, some mid-size, a few exactly full, and
      // some that overrun the store so later keys, the closing one among them,
      // are dropped.
      while (beats_total < ITEM_TARGET) begin
         sel = $urandom_range(0, 99);
         if (sel < 50)      n = $urandom_range(1, 8);
         else if (sel < 75) n = $urandom_range(9, CAP - 1);
         else if (sel < 85) n = CAP;
         else               n = $urandom_range(CAP + 1, CAP + 8);
         mode = $urandom_range(0, 3);
         calm = ($urandom_range(0, 9) < 3);
         for (int i = 0; i < n; i++) begin
            case (mode)
               1: k = key_type'(int'($urandom_range(0, 8)) - 4);
               2: begin
                  case ($urandom_range(0, 3))
                     0: k = 32'sh8000_0000;
                     1: k = 32'sh7fff_ffff;
                     2: k = '0;
                     default: k = -32'sd1;
                  endcase
               end
               default: k = key_type'($urandom);
            endcase
            add_key(k, (i == n - 1),
                    (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to be taken and every expected result to arrive,
      // then give the block a little longer to show anything stray.
      @(negedge clock);
      while (beats_accepted < beats_total || sorted_expect.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("Run covered %0d key beats in %0d batches, %0d of them over capacity.",
               beats_accepted, batches_closed, overflow_batches);
      $display("Checked %0d sorted results; %0d mismatches.",
               results_checked, mismatch_count);
      if (mismatch_count == 0 && sorted_expect.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/hse_pkg.sv
src/hse_cmp.sv
src/hse_core.sv
src/heap_sort_engine.sv
dv/tb.sv
